>>> rtl/csvtok_pkg.sv
package csvtok_pkg;

    // character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // result kinds
    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_FEND   = 3'd1;
    localparam logic [2:0] KIND_REND   = 3'd2;
    localparam logic [2:0] KIND_UNTERM = 3'd3;
    localparam logic [2:0] KIND_MIDQ   = 3'd4;

    // parser modes
    typedef enum logic [2:0] {
        MODE_REC     = 3'd0,
        MODE_FIELD0  = 3'd1,
        MODE_PLAIN   = 3'd2,
        MODE_QUOTED  = 3'd3,
        MODE_QSEEN   = 3'd4,
        MODE_DISCARD = 3'd5
    } mode_t;

    // one decoded result word from the parser core
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [2:0] kind;
    } result_t;

endpackage

>>> rtl/csvtok_core.sv
module csvtok_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               op,
    input  logic [7:0]         in_byte,
    input  logic               load_ok,
    output csvtok_pkg::result_t res
);
    import csvtok_pkg::*;

    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [7:0] s1_byte_reg;
    mode_t      mode_reg;
    mode_t      mode_next;
    mode_t      eff;
    logic       hit;
    logic [7:0] data;
    logic [2:0] kind;
    logic       advance;
    logic       accept;

    // unused codes behave as start of record
    always_comb
    begin
        unique case (mode_reg)
            MODE_REC:     eff = MODE_REC;
            MODE_FIELD0:  eff = MODE_FIELD0;
            MODE_PLAIN:   eff = MODE_PLAIN;
            MODE_QUOTED:  eff = MODE_QUOTED;
            MODE_QSEEN:   eff = MODE_QSEEN;
            MODE_DISCARD: eff = MODE_DISCARD;
            default:      eff = MODE_REC;
        endcase
    end

    // per-character decode
    always_comb
    begin
        hit       = 1'b0;
        data      = 8'h00;
        kind      = KIND_DATA;
        mode_next = eff;
        if (s1_op_reg)
        begin
            mode_next = MODE_REC;
            if (eff == MODE_QUOTED)
            begin
                hit  = 1'b1;
                kind = KIND_UNTERM;
            end
            else if (eff == MODE_FIELD0 || eff == MODE_PLAIN || eff == MODE_QSEEN)
            begin
                hit  = 1'b1;
                kind = KIND_REND;
            end
        end
        else if (s1_byte_reg != CH_CR)
        begin
            unique case (eff)
                MODE_DISCARD:
                begin
                    if (s1_byte_reg == CH_NL)
                    begin
                        mode_next = MODE_REC;
                    end
                end
                MODE_QUOTED:
                begin
                    priority if (s1_byte_reg == CH_NL)
                    begin
                        mode_next = MODE_REC;
                        hit       = 1'b1;
                        kind      = KIND_UNTERM;
                    end
                    else if (s1_byte_reg == CH_QUOTE)
                    begin
                        mode_next = MODE_QSEEN;
                    end
                    else
                    begin
                        hit  = 1'b1;
                        data = s1_byte_reg;
                    end
                end
                default:
                begin
                    priority if (eff == MODE_QSEEN && s1_byte_reg == CH_QUOTE)
                    begin
                        // doubled quote inside a quoted field
                        mode_next = MODE_QUOTED;
                        hit       = 1'b1;
                        data      = CH_QUOTE;
                    end
                    else if (s1_byte_reg == CH_NL)
                    begin
                        mode_next = MODE_REC;
                        if (eff != MODE_REC)
                        begin
                            hit  = 1'b1;
                            kind = KIND_REND;
                        end
                    end
                    else if (s1_byte_reg == CH_COMMA)
                    begin
                        mode_next = MODE_FIELD0;
                        hit       = 1'b1;
                        kind      = KIND_FEND;
                    end
                    else if (s1_byte_reg == CH_QUOTE)
                    begin
                        if (eff == MODE_PLAIN)
                        begin
                            mode_next = MODE_DISCARD;
                            hit       = 1'b1;
                            kind      = KIND_MIDQ;
                        end
                        else
                        begin
                            mode_next = MODE_QUOTED;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_PLAIN;
                        hit       = 1'b1;
                        data      = s1_byte_reg;
                    end
                end
            endcase
        end
    end

    // handshake with the input register
    assign advance   = s1_valid_reg && (!hit || load_ok);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    assign res.valid = s1_valid_reg && hit;
    assign res.data  = data;
    assign res.kind  = kind;

    // input register and mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mode_reg     <= MODE_REC;
        end
        else
        begin
            if (advance)
            begin
                mode_reg <= mode_next;
            end
            if (accept || advance)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= op;
            s1_byte_reg <= in_byte;
        end
    end

endmodule

>>> rtl/csvtok_out.sv
module csvtok_out (
    input  logic               clk,
    input  logic               rst_n,
    input  csvtok_pkg::result_t res,
    output logic               load_ok,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [7:0]         out_byte,
    output logic [2:0]         kind
);
    import csvtok_pkg::*;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] kind_reg;

    // result register may load when empty or being taken
    assign load_ok = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            out_valid_reg <= res.valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_ok && res.valid)
        begin
            out_byte_reg <= res.data;
            kind_reg     <= res.kind;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign kind      = kind_reg;

endmodule

>>> rtl/csv_field_tokenizer.sv
// csv_field_tokenizer: streaming csv tokenizer, one character per word
// request channel: req_valid / req_stall with op (0 byte, 1 end of input)
//   and in_byte; a word is taken when req_valid is high and req_stall low
// response channel: rsp_valid / rsp_stall with out_byte and kind
//   (0 data, 1 field end, 2 record end, 3 unterminated quote,
//   4 quote mid-field); each request word yields zero or one response word
// throughput: one word per cycle while no stall holds the input register,
//   set by the combinational decode between input and result registers
// path: a request word is taken into the input register, decoded, and its
//   result loaded into the result register, which drives the response channel
// reset: both registers empty, parser at start of record
// stall: while the result register holds a word and rsp_stall is high, a
//   request whose decode gives a result waits in the input register and
//   req_stall rises; words that give no result still pass through
module csv_field_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       op,
    input  logic [7:0] in_byte,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] out_byte,
    output logic [2:0] kind
);
    import csvtok_pkg::*;

    result_t res;
    logic    load_ok;

    // parser core with input register and mode state
    csvtok_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .in_byte   (in_byte),
        .load_ok   (load_ok),
        .res       (res)
    );

    // result register
    csvtok_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .load_ok   (load_ok),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .out_byte  (out_byte),
        .kind      (kind)
    );

endmodule

>>> tb/tb_csv_field_tokenizer.sv
`timescale 1ns / 1ps

module tb_csv_field_tokenizer;

    import csvtok_pkg::*;

    // request op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int RANDOM_WORDS = 730;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 16;

    // one request word, with an optional hand-typed expectation
    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       known;
        logic       known_has;
        logic [7:0] known_byte;
        logic [2:0] known_kind;
    } char_word_t;

    // one expected response word
    typedef struct packed {
        logic [7:0] tok_byte;
        logic [2:0] tok_kind;
    } token_t;

    // directed words: typed expectation where it is plain, else predicted
    localparam char_word_t DIRECTED_ROWS [0:25] = '{
        '{OP_BYTE, 8'h61,    1'b1, 1'b1, 8'h61, KIND_DATA},   // first byte after reset
        '{OP_BYTE, CH_COMMA, 1'b1, 1'b1, 8'h00, KIND_FEND},
        '{OP_BYTE, CH_NL,    1'b1, 1'b1, 8'h00, KIND_REND},   // trailing comma
        '{OP_BYTE, CH_NL,    1'b1, 1'b0, 8'h00, KIND_DATA},   // blank line
        '{OP_BYTE, CH_CR,    1'b1, 1'b0, 8'h00, KIND_DATA},
        '{OP_BYTE, CH_NL,    1'b1, 1'b0, 8'h00, KIND_DATA},   // line of only cr
        '{OP_BYTE, 8'h00,    1'b1, 1'b1, 8'h00, KIND_DATA},   // byte extremes
        '{OP_BYTE, 8'hFF,    1'b1, 1'b1, 8'hFF, KIND_DATA},
        '{OP_BYTE, CH_QUOTE, 1'b1, 1'b1, 8'h00, KIND_MIDQ},   // quote mid-field
        '{OP_BYTE, 8'h78,    1'b1, 1'b0, 8'h00, KIND_DATA},   // discarded
        '{OP_BYTE, CH_NL,    1'b1, 1'b0, 8'h00, KIND_DATA},   // leaves discard
        '{OP_BYTE, CH_QUOTE, 1'b0, 1'b0, 8'h00, KIND_DATA},   // open quoted field
        '{OP_BYTE, CH_COMMA, 1'b0, 1'b0, 8'h00, KIND_DATA},   // comma as content
        '{OP_BYTE, CH_QUOTE, 1'b0, 1'b0, 8'h00, KIND_DATA},
        '{OP_BYTE, CH_QUOTE, 1'b0, 1'b0, 8'h00, KIND_DATA},   // doubled quote
        '{OP_BYTE, CH_QUOTE, 1'b0, 1'b0, 8'h00, KIND_DATA},
        '{OP_BYTE, 8'h7A,    1'b0, 1'b0, 8'h00, KIND_DATA},   // text after closing quote
        '{OP_END,  8'hA5,    1'b0, 1'b0, 8'h00, KIND_DATA},   // end of input in field
        '{OP_BYTE, CH_QUOTE, 1'b0, 1'b0, 8'h00, KIND_DATA},
        '{OP_BYTE, CH_NL,    1'b1, 1'b1, 8'h00, KIND_UNTERM}, // newline inside quote
        '{OP_BYTE, CH_QUOTE, 1'b0, 1'b0, 8'h00, KIND_DATA},
        '{OP_END,  8'hFF,    1'b1, 1'b1, 8'h00, KIND_UNTERM}, // end inside quote
        '{OP_END,  8'h00,    1'b1, 1'b0, 8'h00, KIND_DATA},   // end at start of record
        '{OP_BYTE, CH_QUOTE, 1'b0, 1'b0, 8'h00, KIND_DATA},
        '{OP_BYTE, CH_QUOTE, 1'b0, 1'b0, 8'h00, KIND_DATA},
        '{OP_BYTE, CH_NL,    1'b0, 1'b0, 8'h00, KIND_DATA}    // empty quoted field
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic       op        = OP_BYTE;
    logic [7:0] in_byte   = 8'h00;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    logic [7:0] out_byte;
    logic [2:0] kind;

    char_word_t byte_stream [$];
    token_t     pending_tokens [$];
    char_word_t on_bus;
    mode_t      parse_state = MODE_REC;
    int         next_word = 0;
    int         stream_words = 0;
    int         words_taken = 0;
    int         tokens_seen = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    int         stall_burst = 0;
    int         kind_seen [0:4] = '{0, 0, 0, 0, 0};
    logic       quiet;

    csv_field_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .in_byte   (in_byte),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .out_byte  (out_byte),
        .kind      (kind)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // no idling on either side through this stretch of words
    assign quiet = (words_taken >= 300) && (words_taken < 450);

    task automatic report_mismatch(input string what);
        if (error_count < 50)
            $display("[%0t] %s", $time, what);
        error_count++;
    endtask

    // append a random-part word and count it unless the block just drops it
    function automatic void add_word(input logic is_end, input logic [7:0] ch);
        byte_stream.push_back('{is_end, ch, 1'b0, 1'b0, 8'h00, KIND_DATA});
        if (is_end || ch != CH_CR)
            stream_words++;
    endfunction

    // tokenizer state machine, one word per call
    function automatic void tokenize_step(
        input  logic       is_end,
        input  logic [7:0] ch,
        output logic       has_tok,
        output logic [7:0] tok_byte,
        output logic [2:0] tok_kind
    );
        mode_t m;
        m = parse_state;
        has_tok  = 1'b0;
        tok_byte = 8'h00;
        tok_kind = KIND_DATA;
        if (is_end)
        begin
            parse_state = MODE_REC;
            if (m == MODE_QUOTED)
            begin
                has_tok  = 1'b1;
                tok_kind = KIND_UNTERM;
            end
            else if (m == MODE_FIELD0 || m == MODE_PLAIN || m == MODE_QSEEN)
            begin
                has_tok  = 1'b1;
                tok_kind = KIND_REND;
            end
        end
        else if (ch == CH_CR)
        begin
            // carriage returns vanish everywhere
        end
        else if (m == MODE_DISCARD)
        begin
            if (ch == CH_NL)
                parse_state = MODE_REC;
        end
        else if (m == MODE_QUOTED)
        begin
            if (ch == CH_NL)
            begin
                parse_state = MODE_REC;
                has_tok     = 1'b1;
                tok_kind    = KIND_UNTERM;
            end
            else if (ch == CH_QUOTE)
                parse_state = MODE_QSEEN;
            else
            begin
                has_tok  = 1'b1;
                tok_byte = ch;
            end
        end
        else if (m == MODE_QSEEN && ch == CH_QUOTE)
        begin
            // second quote of a doubled pair
            parse_state = MODE_QUOTED;
            has_tok     = 1'b1;
            tok_byte    = CH_QUOTE;
        end
        else if (ch == CH_NL)
        begin
            parse_state = MODE_REC;
            if (m != MODE_REC)
            begin
                has_tok  = 1'b1;
                tok_kind = KIND_REND;
            end
        end
        else if (ch == CH_COMMA)
        begin
            parse_state = MODE_FIELD0;
            has_tok     = 1'b1;
            tok_kind    = KIND_FEND;
        end
        else if (ch == CH_QUOTE)
        begin
            if (m == MODE_PLAIN)
            begin
                parse_state = MODE_DISCARD;
                has_tok     = 1'b1;
                tok_kind    = KIND_MIDQ;
            end
            else
                parse_state = MODE_QUOTED;
        end
        else
        begin
            parse_state = MODE_PLAIN;
            has_tok     = 1'b1;
            tok_byte    = ch;
        end
    endfunction

    // request side: account for the taken word, then offer the next one
    always @(posedge clk)
    begin : req_driver
        logic       has_tok;
        logic [7:0] tok_byte;
        logic [2:0] tok_kind;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                tokenize_step(on_bus.op, on_bus.ch, has_tok, tok_byte, tok_kind);
                words_taken++;
                if (on_bus.known)
                begin
                    if (on_bus.known_has)
                        pending_tokens.push_back('{on_bus.known_byte, on_bus.known_kind});
                end
                else if (has_tok)
                    pending_tokens.push_back('{tok_byte, tok_kind});
            end
            if (!req_valid || !req_stall)
            begin
                if (next_word < byte_stream.size() && (quiet || $urandom_range(0, 99) >= 9))
                begin
                    on_bus    <= byte_stream[next_word];
                    req_valid <= 1'b1;
                    op        <= byte_stream[next_word].op;
                    in_byte   <= byte_stream[next_word].ch;
                    next_word <= next_word + 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response side: check each taken word, then pick the next stall
    always @(posedge clk)
    begin : rsp_checker
        token_t want;
        int     r;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                tokens_seen++;
                if (kind <= KIND_MIDQ)
                    kind_seen[kind]++;
                if (pending_tokens.size() == 0)
                    report_mismatch($sformatf("unexpected word: out_byte %h kind %0d",
                                              out_byte, kind));
                else
                begin
                    want = pending_tokens.pop_front();
                    if (kind !== want.tok_kind)
                        report_mismatch($sformatf("word %0d: kind %0d, expected %0d",
                                                  tokens_seen, kind, want.tok_kind));
                    if (out_byte !== want.tok_byte)
                        report_mismatch($sformatf("word %0d: out_byte %h, expected %h",
                                                  tokens_seen, out_byte, want.tok_byte));
                end
            end
            // short stalls, now and then a longer one
            r = $urandom_range(0, 99);
            if (quiet)
            begin
                stall_burst = 0;
                rsp_stall <= 1'b0;
            end
            else if (stall_burst > 0)
            begin
                stall_burst--;
                rsp_stall <= 1'b1;
            end
            else if (r == 0)
            begin
                stall_burst = $urandom_range(2, 8);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= (r < 6);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout: %0d words taken, %0d results still pending",
                     words_taken, pending_tokens.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : main_seq
        int         nf;
        int         len;
        int         r;
        logic [7:0] b;
        foreach (DIRECTED_ROWS[i])
            byte_stream.push_back(DIRECTED_ROWS[i]);

        // random part: mostly well-formed records, some noise
        while (stream_words < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                nf = $urandom_range(1, 4);
                for (int f = 0; f < nf; f++)
                begin
                    if (f != 0)
                        add_word(OP_BYTE, CH_COMMA);
                    len = $urandom_range(0, 5);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        // quoted field with commas, doubled quotes and cr inside
                        add_word(OP_BYTE, CH_QUOTE);
                        for (int c = 0; c < len; c++)
                        begin
                            r = $urandom_range(0, 9);
                            if (r == 0)
                            begin
                                add_word(OP_BYTE, CH_QUOTE);
                                add_word(OP_BYTE, CH_QUOTE);
                            end
                            else if (r == 1)
                                add_word(OP_BYTE, CH_COMMA);
                            else if (r == 2)
                                add_word(OP_BYTE, CH_CR);
                            else
                            begin
                                do
                                    b = 8'($urandom_range(0, 255));
                                while (b == CH_QUOTE || b == CH_NL);
                                add_word(OP_BYTE, b);
                            end
                        end
                        add_word(OP_BYTE, CH_QUOTE);
                    end
                    else
                    begin
                        // plain field
                        for (int c = 0; c < len; c++)
                        begin
                            do
                                b = 8'($urandom_range(0, 255));
                            while (b == CH_QUOTE || b == CH_NL || b == CH_CR || b == CH_COMMA);
                            add_word(OP_BYTE, b);
                        end
                    end
                end
                // record end: newline, cr newline, blank line after, or end of input
                r = $urandom_range(0, 9);
                if (r == 0)
                    add_word(OP_END, 8'($urandom_range(0, 255)));
                else
                begin
                    if (r == 1)
                        add_word(OP_BYTE, CH_CR);
                    add_word(OP_BYTE, CH_NL);
                    if (r == 2)
                        add_word(OP_BYTE, CH_NL);
                end
            end
            else
            begin
                // noise: random bytes, heavy on special characters
                len = $urandom_range(1, 6);
                for (int c = 0; c < len; c++)
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        add_word(OP_END, 8'($urandom_range(0, 255)));
                    else if (r < 9)
                    begin
                        case ($urandom_range(0, 3))
                            0:       add_word(OP_BYTE, CH_NL);
                            1:       add_word(OP_BYTE, CH_CR);
                            2:       add_word(OP_BYTE, CH_COMMA);
                            default: add_word(OP_BYTE, CH_QUOTE);
                        endcase
                    end
                    else
                        add_word(OP_BYTE, 8'($urandom_range(0, 255)));
                end
            end
        end

        // reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // run until every word is taken and every result has come back
        do
            @(negedge clk);
        while (next_word < byte_stream.size() || req_valid || pending_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d request words (%0d directed), checked %0d result words",
                 words_taken, $size(DIRECTED_ROWS), tokens_seen);
        $display("results by kind: data %0d, field end %0d, record end %0d, unterm %0d, midq %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
